[src/bfc_pkg.sv]
// Shared types and constants for the box frustum cull block.
// Used by bfc_plane_test and box_frustum_cull_core; depends on nothing else.

package bfc_pkg;

    // Field widths. Coordinates and coefficients are Q16.16 two's complement.
    localparam int COORD_WIDTH = 32;
    localparam int COEF_WIDTH  = 32;
    localparam int CFG_WIDTH   = 32;
    localparam int FRAC_BITS   = 16;

    // Exact product is Q32.32. Three products plus the offset fit in two more bits.
    localparam int PROD_WIDTH  = COEF_WIDTH + COORD_WIDTH;
    localparam int SUM_WIDTH   = PROD_WIDTH + 2;
    localparam int CMP_WIDTH   = SUM_WIDTH + 1;

    localparam int NUM_ROWS    = 3;
    localparam int NUM_COLS    = 4;
    localparam int NUM_AXES    = 3;
    localparam int NUM_CORNERS = 8;

    // Operation codes.
    localparam logic OP_LOAD_ROW = 1'b0;
    localparam logic OP_TEST_BOX = 1'b1;

    // Matrix rows and columns.
    localparam logic [1:0] ROW_X      = 2'd0;
    localparam logic [1:0] ROW_Y      = 2'd1;
    localparam logic [1:0] ROW_Z      = 2'd2;
    localparam logic [1:0] ROW_UNUSED = 2'd3;

    localparam int COL_X      = 0;
    localparam int COL_Y      = 1;
    localparam int COL_Z      = 2;
    localparam int COL_OFFSET = 3;

    // Configuration register indexes.
    localparam logic CFG_NEAR_PLANE = 1'b0;
    localparam logic CFG_FAR_PLANE  = 1'b1;

    localparam logic signed [CFG_WIDTH-1:0] NEAR_PLANE_RESET = 32'sd65536;
    localparam logic signed [CFG_WIDTH-1:0] FAR_PLANE_RESET  = 32'sd2147483647;

    // Clipping distances handed to the plane test.
    typedef struct packed {
        logic signed [CFG_WIDTH-1:0] near_plane;
        logic signed [CFG_WIDTH-1:0] far_plane;
    } t_planes;

    typedef logic signed [SUM_WIDTH-1:0] t_cam_coord;

endpackage

[src/bfc_plane_test.sv]
// Six-plane test of the eight transformed box corners.
// Depends on bfc_pkg for widths and the plane struct.

module bfc_plane_test
    import bfc_pkg::*;
(
    input  t_planes    i_planes,
    input  t_cam_coord i_corner_x [NUM_CORNERS],
    input  t_cam_coord i_corner_y [NUM_CORNERS],
    input  t_cam_coord i_corner_z [NUM_CORNERS],
    output logic       o_visible
);

    localparam int NUM_TESTS  = 6;
    localparam int TEST_NEAR  = 0;
    localparam int TEST_FAR   = 1;
    localparam int TEST_LEFT  = 2;
    localparam int TEST_RIGHT = 3;
    localparam int TEST_BOT   = 4;
    localparam int TEST_TOP   = 5;

    t_cam_coord                   near_w;
    t_cam_coord                   far_w;
    logic        [NUM_TESTS-1:0]  any_pass;
    logic signed [CMP_WIDTH-1:0]  sum_xz;
    logic signed [CMP_WIDTH-1:0]  dif_xz;
    logic signed [CMP_WIDTH-1:0]  sum_yz;
    logic signed [CMP_WIDTH-1:0]  dif_yz;

    // Planes raised to Q32.32 so they line up with the camera-space sums.
    assign near_w = SUM_WIDTH'($signed({i_planes.near_plane, {FRAC_BITS{1'b0}}}));
    assign far_w  = SUM_WIDTH'($signed({i_planes.far_plane, {FRAC_BITS{1'b0}}}));

    // A test survives if at least one corner passes it; all six must survive.
    always_comb begin
        any_pass = '0;
        sum_xz   = '0;
        dif_xz   = '0;
        sum_yz   = '0;
        dif_yz   = '0;
        for (int n = 0; n < NUM_CORNERS; n++) begin
            sum_xz = CMP_WIDTH'(i_corner_z[n]) + CMP_WIDTH'(i_corner_x[n]);
            dif_xz = CMP_WIDTH'(i_corner_z[n]) - CMP_WIDTH'(i_corner_x[n]);
            sum_yz = CMP_WIDTH'(i_corner_z[n]) + CMP_WIDTH'(i_corner_y[n]);
            dif_yz = CMP_WIDTH'(i_corner_z[n]) - CMP_WIDTH'(i_corner_y[n]);
            if (near_w < i_corner_z[n]) any_pass[TEST_NEAR] = 1'b1;
            if (i_corner_z[n] < far_w)  any_pass[TEST_FAR]  = 1'b1;
            // -x < z and x < z reduce to the sign of z + x and z - x.
            if (!sum_xz[CMP_WIDTH-1] && (sum_xz != '0)) any_pass[TEST_LEFT]  = 1'b1;
            if (!dif_xz[CMP_WIDTH-1] && (dif_xz != '0)) any_pass[TEST_RIGHT] = 1'b1;
            if (!sum_yz[CMP_WIDTH-1] && (sum_yz != '0)) any_pass[TEST_BOT]   = 1'b1;
            if (!dif_yz[CMP_WIDTH-1] && (dif_yz != '0)) any_pass[TEST_TOP]   = 1'b1;
        end
    end

    assign o_visible = &any_pass;

endmodule

[src/box_frustum_cull_core.sv]
// Top level of the box frustum cull block: matrix store, five-register pipeline.
// Depends on bfc_pkg and bfc_plane_test.
//
// Usage:
// - Input channel (i_in_valid / o_in_ready) carries one transaction per item.
//   A load-row transaction writes one row of the 3x4 camera matrix and gives
//   no result; row index three is ignored. A test-box transaction gives one
//   result on the output channel (o_out_valid / i_out_ready, o_visible).
// - Configuration channel (i_cfg_valid / o_cfg_ready) writes near_plane
//   (index 0) or far_plane (index 1); it is always ready. Write it only
//   while no test is in flight.
// - Throughput is one item per cycle while the receiver takes results; the
//   pipeline has five registers (input, products, partial sums, corners,
//   result), and a load may be followed by a test in the very next cycle.
// - The eight corners come from 18 multipliers: each matrix coefficient
//   times the box's min and max on its axis, since the transform is linear.
// - Reset clears the matrix to zero, loads the default planes and empties
//   the pipeline. When the receiver stalls, results collect in the pipeline
//   and bubbles close up; input is refused only once every stage is full.

module box_frustum_cull_core
    import bfc_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Item channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_operation,
    input  logic [1:0]                    i_row_index,
    input  logic signed [COEF_WIDTH-1:0]  i_coef_x,
    input  logic signed [COEF_WIDTH-1:0]  i_coef_y,
    input  logic signed [COEF_WIDTH-1:0]  i_coef_z,
    input  logic signed [COEF_WIDTH-1:0]  i_coef_offset,
    input  logic signed [COORD_WIDTH-1:0] i_min_x,
    input  logic signed [COORD_WIDTH-1:0] i_min_y,
    input  logic signed [COORD_WIDTH-1:0] i_min_z,
    input  logic signed [COORD_WIDTH-1:0] i_max_x,
    input  logic signed [COORD_WIDTH-1:0] i_max_y,
    input  logic signed [COORD_WIDTH-1:0] i_max_z,
    // Result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_visible,
    // Configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [CFG_WIDTH-1:0]          i_cfg_data
);

    // Stage advance enables, from the output back.
    logic en_s0;
    logic en_s1;
    logic en_s2;
    logic en_s3;
    logic en_s4;

    // Configuration and matrix state.
    t_planes                                      r_planes;
    logic [NUM_ROWS-1:0][NUM_COLS-1:0][COEF_WIDTH-1:0] r_matrix;

    // Stage 0: input register.
    logic                                r_v0;
    logic                                r_s0_op;
    logic [1:0]                          r_s0_row;
    logic [NUM_COLS-1:0][COEF_WIDTH-1:0] r_s0_coef;
    logic signed [COORD_WIDTH-1:0]       r_s0_lo [NUM_AXES];
    logic signed [COORD_WIDTH-1:0]       r_s0_hi [NUM_AXES];

    // Stage 1: products of each coefficient with the min and max bound.
    logic                         r_v1;
    logic signed [PROD_WIDTH-1:0] r_s1_prod [NUM_ROWS][NUM_AXES][2];
    logic signed [PROD_WIDTH-1:0] n_prod    [NUM_ROWS][NUM_AXES][2];
    logic signed [COEF_WIDTH-1:0] r_s1_off  [NUM_ROWS];

    // Stage 2: offset plus x term, and the four y plus z combinations.
    logic       r_v2;
    t_cam_coord r_s2_xpart  [NUM_ROWS][2];
    t_cam_coord n_xpart     [NUM_ROWS][2];
    t_cam_coord r_s2_yzpart [NUM_ROWS][4];
    t_cam_coord n_yzpart    [NUM_ROWS][4];

    // Stage 3: camera-space coordinates of all eight corners.
    logic       r_v3;
    t_cam_coord r_s3_corner [NUM_ROWS][NUM_CORNERS];
    t_cam_coord n_corner    [NUM_ROWS][NUM_CORNERS];

    // Stage 4: result register.
    logic r_v4;
    logic r_s4_visible;
    logic n_visible;

    // A load completes in stage 0, so it never waits for stage 1.
    assign en_s4      = !r_v4 || i_out_ready;
    assign en_s3      = !r_v3 || en_s4;
    assign en_s2      = !r_v2 || en_s3;
    assign en_s1      = !r_v1 || en_s2;
    assign en_s0      = !r_v0 || (r_s0_op == OP_LOAD_ROW) || en_s1;
    assign o_in_ready = en_s0;
    assign o_cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planes.near_plane <= NEAR_PLANE_RESET;
            r_planes.far_plane  <= FAR_PLANE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NEAR_PLANE: r_planes.near_plane <= $signed(i_cfg_data);
                CFG_FAR_PLANE:  r_planes.far_plane  <= $signed(i_cfg_data);
            endcase
        end
    end

    // Matrix rows are written when a load leaves stage 0, in item order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix <= '0;
        end else if (r_v0 && en_s0 && (r_s0_op == OP_LOAD_ROW)
                     && (r_s0_row != ROW_UNUSED)) begin
            r_matrix[r_s0_row] <= r_s0_coef;
        end
    end

    // Stage 0 register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en_s0) begin
            r_v0 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s0 && i_in_valid) begin
            r_s0_op    <= i_operation;
            r_s0_row   <= i_row_index;
            r_s0_coef  <= {i_coef_offset, i_coef_z, i_coef_y, i_coef_x};
            r_s0_lo[0] <= i_min_x;
            r_s0_lo[1] <= i_min_y;
            r_s0_lo[2] <= i_min_z;
            r_s0_hi[0] <= i_max_x;
            r_s0_hi[1] <= i_max_y;
            r_s0_hi[2] <= i_max_z;
        end
    end

    // Exact Q32.32 products of every coefficient with both bounds of its axis.
    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                n_prod[r][k][0] = PROD_WIDTH'($signed(r_matrix[r][k]))
                                * PROD_WIDTH'(r_s0_lo[k]);
                n_prod[r][k][1] = PROD_WIDTH'($signed(r_matrix[r][k]))
                                * PROD_WIDTH'(r_s0_hi[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en_s1) begin
            r_v1 <= r_v0 && (r_s0_op == OP_TEST_BOX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            r_s1_prod <= n_prod;
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_s1_off[r] <= $signed(r_matrix[r][COL_OFFSET]);
            end
        end
    end

    // Partial sums: offset with the x term, and every y and z pairing.
    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int h = 0; h < 2; h++) begin
                n_xpart[r][h] = SUM_WIDTH'(r_s1_prod[r][COL_X][h])
                              + SUM_WIDTH'($signed({r_s1_off[r], {FRAC_BITS{1'b0}}}));
            end
            for (int j = 0; j < 4; j++) begin
                n_yzpart[r][j] = SUM_WIDTH'(r_s1_prod[r][COL_Y][j[0]])
                               + SUM_WIDTH'(r_s1_prod[r][COL_Z][j[1]]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en_s2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s2) begin
            r_s2_xpart  <= n_xpart;
            r_s2_yzpart <= n_yzpart;
        end
    end

    // Corner n takes the max bound on axis k when bit k of n is set.
    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int n = 0; n < NUM_CORNERS; n++) begin
                n_corner[r][n] = r_s2_xpart[r][n[0]] + r_s2_yzpart[r][n[2:1]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en_s3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s3) begin
            r_s3_corner <= n_corner;
        end
    end

    // Plane tests over the eight corners.
    bfc_plane_test u_plane_test (
        .i_planes   (r_planes),
        .i_corner_x (r_s3_corner[ROW_X]),
        .i_corner_y (r_s3_corner[ROW_Y]),
        .i_corner_z (r_s3_corner[ROW_Z]),
        .o_visible  (n_visible)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en_s4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s4) begin
            r_s4_visible <= n_visible;
        end
    end

    assign o_out_valid = r_v4;
    assign o_visible   = r_s4_visible;

    // A load leaving stage 0 must not start a result.
    a_load_gives_no_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_v0 && en_s1 && (r_s0_op == OP_LOAD_ROW)) |=> !r_v1
    ) else $error("load transaction entered the product stage");

    // The matrix only changes when a load leaves stage 0.
    a_matrix_held: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !(r_v0 && en_s0 && (r_s0_op == OP_LOAD_ROW)) |=> $stable(r_matrix)
    ) else $error("matrix changed without a load transaction");

    // A free output register means the whole pipeline can take an item.
    a_ready_when_drained: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (!r_v4 || i_out_ready) |-> o_in_ready
    ) else $error("input refused while the output side is free");

    // A stalled corner stage keeps its item and sits behind a full output.
    a_stall_keeps_item: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !en_s3) |=> (r_v3 && r_v4)
    ) else $error("stalled corner stage lost its transaction");

endmodule

[tb/tb.sv]
// Self-checking testbench for box_frustum_cull_core: directed and random boxes and plane settings.
// Depends on bfc_pkg and the box_frustum_cull_core RTL; the visibility predictor is in this file.
`timescale 1ns / 1ps

import bfc_pkg::*;

// One transaction on the item channel.
typedef struct packed {
    logic                          op;
    logic [1:0]                    row_index;
    logic signed [COEF_WIDTH-1:0]  coef_x;
    logic signed [COEF_WIDTH-1:0]  coef_y;
    logic signed [COEF_WIDTH-1:0]  coef_z;
    logic signed [COEF_WIDTH-1:0]  coef_offset;
    logic signed [COORD_WIDTH-1:0] min_x;
    logic signed [COORD_WIDTH-1:0] min_y;
    logic signed [COORD_WIDTH-1:0] min_z;
    logic signed [COORD_WIDTH-1:0] max_x;
    logic signed [COORD_WIDTH-1:0] max_y;
    logic signed [COORD_WIDTH-1:0] max_z;
} t_box_item;

// Keeps a private copy of the camera matrix and planes, predicts visibility
// for every accepted box and checks the results in order.
class cull_scoreboard;
    logic signed [COEF_WIDTH-1:0] camera [0:NUM_ROWS-1][0:NUM_COLS-1];
    logic signed [CFG_WIDTH-1:0]  near_q;
    logic signed [CFG_WIDTH-1:0]  far_q;
    logic                         visible_q[$];
    int                           errors;

    function new();
        int r;
        int c;
        for (r = 0; r < NUM_ROWS; r++) begin
            for (c = 0; c < NUM_COLS; c++) begin
                camera[r][c] = '0;
            end
        end
        near_q = NEAR_PLANE_RESET;
        far_q  = FAR_PLANE_RESET;
        errors = 0;
    endfunction

    function int pending();
        return visible_q.size();
    endfunction

    function void write_plane(logic idx, logic [CFG_WIDTH-1:0] data);
        if (idx == CFG_NEAR_PLANE) begin
            near_q = data;
        end else begin
            far_q = data;
        end
    endfunction

    // Exact camera-space coordinate of one point: row . (x, y, z) + offset, in Q32.32.
    function logic signed [127:0] camera_coord(int r, logic signed [COORD_WIDTH-1:0] px,
                                               logic signed [COORD_WIDTH-1:0] py,
                                               logic signed [COORD_WIDTH-1:0] pz);
        logic signed [127:0] acc;
        logic signed [127:0] cw;
        logic signed [127:0] pw;
        acc = camera[r][COL_OFFSET];
        acc = acc <<< FRAC_BITS;
        cw = camera[r][COL_X];
        pw = px;
        acc = acc + cw * pw;
        cw = camera[r][COL_Y];
        pw = py;
        acc = acc + cw * pw;
        cw = camera[r][COL_Z];
        pw = pz;
        acc = acc + cw * pw;
        return acc;
    endfunction

    // A box is culled only when all eight corners fail one and the same plane.
    function logic predict_visible(t_box_item it);
        logic signed [127:0]           near_w;
        logic signed [127:0]           far_w;
        logic signed [127:0]           cx;
        logic signed [127:0]           cy;
        logic signed [127:0]           cz;
        logic signed [COORD_WIDTH-1:0] px;
        logic signed [COORD_WIDTH-1:0] py;
        logic signed [COORD_WIDTH-1:0] pz;
        logic [5:0]                    passed;
        int                            n;
        near_w = near_q;
        near_w = near_w <<< FRAC_BITS;
        far_w  = far_q;
        far_w  = far_w <<< FRAC_BITS;
        passed = '0;
        for (n = 0; n < NUM_CORNERS; n++) begin
            px = n[0] ? it.max_x : it.min_x;
            py = n[1] ? it.max_y : it.min_y;
            pz = n[2] ? it.max_z : it.min_z;
            cx = camera_coord(ROW_X, px, py, pz);
            cy = camera_coord(ROW_Y, px, py, pz);
            cz = camera_coord(ROW_Z, px, py, pz);
            if (cz > near_w) passed[0] = 1'b1;
            if (cz < far_w)  passed[1] = 1'b1;
            if (-cx < cz)    passed[2] = 1'b1;
            if (cx < cz)     passed[3] = 1'b1;
            if (-cy < cz)    passed[4] = 1'b1;
            if (cy < cz)     passed[5] = 1'b1;
        end
        return (passed == 6'h3f);
    endfunction

    // Called for every accepted item transaction.
    function void note_item(t_box_item it);
        if (it.op == OP_LOAD_ROW) begin
            if (it.row_index != ROW_UNUSED) begin
                camera[it.row_index][COL_X]      = it.coef_x;
                camera[it.row_index][COL_Y]      = it.coef_y;
                camera[it.row_index][COL_Z]      = it.coef_z;
                camera[it.row_index][COL_OFFSET] = it.coef_offset;
            end
        end else begin
            visible_q.push_back(predict_visible(it));
        end
    endfunction

    // Called for every accepted result transaction.
    function void check_visible(logic got);
        logic want;
        if (visible_q.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("unexpected result: visible %0b with no box outstanding", got);
            end
        end else begin
            want = visible_q.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("visible mismatch: expected %0b, actual %0b", want, got);
                end
            end
        end
    endfunction
endclass

module tb;
    localparam int ONE           = 65536;
    localparam int DRAIN_CYCLES  = 8;
    localparam int STALL_CYCLES  = 300;
    localparam int WATCHDOG      = 3000;
    localparam int PHASE_ITEMS   = 200;
    localparam logic signed [31:0] Q_MIN = 32'h8000_0000;
    localparam logic signed [31:0] Q_MAX = 32'h7fff_ffff;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic                          i_operation = OP_LOAD_ROW;
    logic [1:0]                    i_row_index = ROW_X;
    logic signed [COEF_WIDTH-1:0]  i_coef_x = '0;
    logic signed [COEF_WIDTH-1:0]  i_coef_y = '0;
    logic signed [COEF_WIDTH-1:0]  i_coef_z = '0;
    logic signed [COEF_WIDTH-1:0]  i_coef_offset = '0;
    logic signed [COORD_WIDTH-1:0] i_min_x = '0;
    logic signed [COORD_WIDTH-1:0] i_min_y = '0;
    logic signed [COORD_WIDTH-1:0] i_min_z = '0;
    logic signed [COORD_WIDTH-1:0] i_max_x = '0;
    logic signed [COORD_WIDTH-1:0] i_max_y = '0;
    logic signed [COORD_WIDTH-1:0] i_max_z = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic                          o_visible;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic                          i_cfg_index = CFG_NEAR_PLANE;
    logic [CFG_WIDTH-1:0]          i_cfg_data = '0;

    // Both sides run without random idling while this is set.
    bit steady = 1'b0;
    // Asks the receiver for one long hold-off.
    bit stall_request = 1'b0;
    int quiet_cycles = 0;

    cull_scoreboard sb = new();

    box_frustum_cull_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_row_index   (i_row_index),
        .i_coef_x      (i_coef_x),
        .i_coef_y      (i_coef_y),
        .i_coef_z      (i_coef_z),
        .i_coef_offset (i_coef_offset),
        .i_min_x       (i_min_x),
        .i_min_y       (i_min_y),
        .i_min_z       (i_min_z),
        .i_max_x       (i_max_x),
        .i_max_y       (i_max_y),
        .i_max_z       (i_max_z),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_visible     (o_visible),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Monitor: every accepted transaction goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb.note_item({i_operation, i_row_index, i_coef_x, i_coef_y, i_coef_z,
                              i_coef_offset, i_min_x, i_min_y, i_min_z,
                              i_max_x, i_max_y, i_max_z});
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_visible(o_visible);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_plane(i_cfg_index, i_cfg_data);
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any transaction.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_request) begin
                stall_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= steady || ($urandom_range(0, 99) >= 8);
        end
    end

    // Random Q16.16 value: mostly small, some whole numbers, some extremes, some raw.
    function automatic logic signed [31:0] rand_q16(input int units);
        int span;
        span = units * ONE;
        case ($urandom_range(0, 11))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0: return Q_MIN;
                    1: return Q_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            2, 3: return (int'($urandom_range(0, 2 * units)) - units) * ONE;
            default: return int'($urandom_range(0, 2 * span)) - span;
        endcase
    endfunction

    function automatic t_box_item make_item(input logic op);
        t_box_item it;
        it.op          = op;
        it.row_index   = ($urandom_range(0, 15) == 0) ? ROW_UNUSED : 2'($urandom_range(0, 2));
        it.coef_x      = rand_q16(2);
        it.coef_y      = rand_q16(2);
        it.coef_z      = rand_q16(2);
        it.coef_offset = rand_q16(16);
        it.min_x       = rand_q16(16);
        it.min_y       = rand_q16(16);
        it.min_z       = rand_q16(16);
        it.max_x       = rand_q16(16);
        it.max_y       = rand_q16(16);
        it.max_z       = rand_q16(16);
        return it;
    endfunction

    function automatic t_box_item load_row(input logic [1:0] row, input logic signed [31:0] cx,
                                           input logic signed [31:0] cy,
                                           input logic signed [31:0] cz,
                                           input logic signed [31:0] co);
        t_box_item it;
        it = '0;
        it.op          = OP_LOAD_ROW;
        it.row_index   = row;
        it.coef_x      = cx;
        it.coef_y      = cy;
        it.coef_z      = cz;
        it.coef_offset = co;
        return it;
    endfunction

    function automatic t_box_item test_box(input logic signed [31:0] x0,
                                           input logic signed [31:0] y0,
                                           input logic signed [31:0] z0,
                                           input logic signed [31:0] x1,
                                           input logic signed [31:0] y1,
                                           input logic signed [31:0] z1);
        t_box_item it;
        it = '0;
        it.op    = OP_TEST_BOX;
        it.min_x = x0;
        it.min_y = y0;
        it.min_z = z0;
        it.max_x = x1;
        it.max_y = y1;
        it.max_z = z1;
        return it;
    endfunction

    // Offers one item after an optional random gap and waits for its transaction.
    task automatic send_item(input t_box_item it);
        while (!steady && $urandom_range(0, 99) < 8) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_operation   <= it.op;
        i_row_index   <= it.row_index;
        i_coef_x      <= it.coef_x;
        i_coef_y      <= it.coef_y;
        i_coef_z      <= it.coef_z;
        i_coef_offset <= it.coef_offset;
        i_min_x       <= it.min_x;
        i_min_y       <= it.min_y;
        i_min_z       <= it.min_z;
        i_max_x       <= it.max_x;
        i_max_y       <= it.max_y;
        i_max_z       <= it.max_z;
        i_in_valid    <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Waits until every expected result is in, then lets the pipeline settle.
    // The first edge makes sure the monitor has noted the last accepted item.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes both clipping planes while the block is idle.
    task automatic set_planes(input logic [CFG_WIDTH-1:0] near_v,
                              input logic [CFG_WIDTH-1:0] far_v);
        int k;
        drain();
        for (k = 0; k < 2; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= (k == 0) ? CFG_NEAR_PLANE : CFG_FAR_PLANE;
            i_cfg_data  <= (k == 0) ? near_v : far_v;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // A camera setup of three rows, then a random mix of loads and box tests.
    task automatic run_phase(input int n_items, input bit with_stall);
        t_box_item it;
        int        r;
        int        n;
        for (r = 0; r < NUM_ROWS; r++) begin
            it = make_item(OP_LOAD_ROW);
            it.row_index = 2'(r);
            if ($urandom_range(0, 3) != 0) begin
                it.coef_x      = (r == 0) ? ONE : 0;
                it.coef_y      = (r == 1) ? ONE : 0;
                it.coef_z      = (r == 2) ? ONE : 0;
                it.coef_offset = (r == 2) ? 8 * ONE : 0;
            end
            send_item(it);
        end
        for (n = 0; n < n_items; n++) begin
            if (with_stall && n == 40) begin
                stall_request = 1'b1;
            end
            send_item(make_item(($urandom_range(0, 99) < 12) ? OP_LOAD_ROW : OP_TEST_BOX));
        end
    endtask

    // Directed cases: zero matrix, ignored row, identity camera against the near and four side
    // planes, strict comparisons on the planes, swapped bounds and extreme values.
    task automatic run_directed();
        t_box_item cases[$];
        int        n;
        cases.push_back(test_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        cases.push_back(load_row(ROW_UNUSED, ONE, ONE, ONE, 4 * ONE));
        cases.push_back(test_box(0, 0, 0, ONE, ONE, ONE));
        cases.push_back(load_row(ROW_X, ONE, 0, 0, 0));
        cases.push_back(load_row(ROW_Y, 0, ONE, 0, 0));
        cases.push_back(load_row(ROW_Z, 0, 0, ONE, 0));
        cases.push_back(test_box(-ONE, -ONE, 2 * ONE, ONE, ONE, 3 * ONE));
        cases.push_back(test_box(-ONE, -ONE, -3 * ONE, ONE, ONE, -2 * ONE));
        cases.push_back(test_box(-10 * ONE, -ONE, 2 * ONE, -9 * ONE, ONE, 3 * ONE));
        cases.push_back(test_box(9 * ONE, -ONE, 2 * ONE, 10 * ONE, ONE, 3 * ONE));
        cases.push_back(test_box(-ONE, -10 * ONE, 2 * ONE, ONE, -9 * ONE, 3 * ONE));
        cases.push_back(test_box(-ONE, 9 * ONE, 2 * ONE, ONE, 10 * ONE, 3 * ONE));
        // Point exactly on the near plane is culled; one step beyond is visible.
        cases.push_back(test_box(0, 0, ONE, 0, 0, ONE));
        cases.push_back(test_box(0, 0, ONE + 1, 0, 0, ONE + 1));
        // Bounds given in the wrong order are used as they stand.
        cases.push_back(test_box(ONE, ONE, 3 * ONE, -ONE, -ONE, 2 * ONE));
        // Point exactly on the right side plane.
        cases.push_back(test_box(2 * ONE, 0, 2 * ONE, 2 * ONE, 0, 2 * ONE));
        cases.push_back(test_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        cases.push_back(load_row(ROW_X, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
        cases.push_back(load_row(ROW_Y, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
        cases.push_back(load_row(ROW_Z, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        cases.push_back(test_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        cases.push_back(test_box(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN));
        cases.push_back(load_row(ROW_Z, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        cases.push_back(test_box(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        cases.push_back(test_box(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        for (n = 0; n < cases.size(); n++) begin
            send_item(cases[n]);
        end
    endtask

    // Main sequence: reset, directed part, then random phases over several plane settings.
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_phase(PHASE_ITEMS, 1'b0);

        set_planes(32'h0000_0000, Q_MAX);
        run_phase(PHASE_ITEMS, 1'b0);

        set_planes(Q_MIN, Q_MAX);
        steady = 1'b1;
        run_phase(PHASE_ITEMS, 1'b0);
        drain();
        steady = 1'b0;

        set_planes(Q_MAX, Q_MIN);
        run_phase(PHASE_ITEMS / 2, 1'b0);

        set_planes(-2 * ONE, 20 * ONE);
        run_phase(PHASE_ITEMS, 1'b1);

        set_planes($urandom_range(0, 2 * ONE), $urandom_range(4 * ONE, 16 * ONE));
        run_phase(PHASE_ITEMS, 1'b0);

        set_planes($urandom, $urandom);
        run_phase(PHASE_ITEMS / 4, 1'b0);

        set_planes(NEAR_PLANE_RESET, FAR_PLANE_RESET);
        run_phase(PHASE_ITEMS / 2, 1'b0);

        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

[box_frustum_cull_core.f]
src/bfc_pkg.sv
src/bfc_plane_test.sv
src/box_frustum_cull_core.sv
tb/tb.sv
